[rtl/dltq_pkg.sv]
// Package with shared types and constants of the delta-list timer queue.
package dltq_pkg;
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int DELTA_BITS_DEF  = 32;
  localparam int MAX_RESULTS     = 16;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ADD  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  timer_id;
    logic [31:0] expires;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       expired_valid;
    logic [3:0] expired_id;
    logic       last;
  } out_item_t;
endpackage

[rtl/dltq_in_if.sv]
// Valid/ready channel interfaces for command items and result items.
interface dltq_in_if;
  logic valid;
  logic ready;
  logic [1:0]  cmd;
  logic [3:0]  timer_id;
  logic [31:0] expires;
  modport source (output valid, cmd, timer_id, expires, input ready);
  modport sink   (input valid, cmd, timer_id, expires, output ready);
endinterface

interface dltq_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic       expired_valid;
  logic [3:0] expired_id;
  logic       last;
  modport source (output valid, status, expired_valid, expired_id, last, input ready);
  modport sink   (input valid, status, expired_valid, expired_id, last, output ready);
endinterface

[rtl/delta_list_timer_queue_core.sv]
// Top level of the delta-list timer queue: list walk sequencer and slot tables.
//
// Channel | Dir | Fields
// in      | in  | cmd, timer_id, expires
// out     | out | status, expired_valid, expired_id, last
//
// One shared subtract/add unit. Add walks the list past at most TIMER_SLOTS - 1 entries,
// then splices the new entry in (S_WALK, S_SPLICE, S_SPLICE2). Delete goes through S_DEL
// and S_DEL2; a rejected or unused command goes straight to the result. A tick decrements
// the head (S_TICK), then each expiry passes S_TCHK, S_TEXP and S_TLAST before it is offered.
// in.ready is high only while idle, from the cycle after the last result is taken.
// Reset (rst, synchronous) empties the list; slot tables need no clearing.
// A stalled result holds the sequencer until out.ready is seen.
module delta_list_timer_queue_core #(
  parameter int TIMER_SLOTS = dltq_pkg::TIMER_SLOTS_DEF,
  parameter int DELTA_BITS  = dltq_pkg::DELTA_BITS_DEF
) (
  input logic clk,
  input logic rst,
  dltq_in_if.sink    in,
  dltq_out_if.source out
);
  import dltq_pkg::*;
  localparam int SW = $clog2(TIMER_SLOTS + 1);
  localparam int IW = $clog2(TIMER_SLOTS);
  localparam logic [SW-1:0] NIL = SW'(TIMER_SLOTS);
  localparam logic [DELTA_BITS-1:0] DMAX = '1;
  localparam int KW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_SPLICE, S_SPLICE2, S_DEL, S_DEL2, S_TICK, S_TCHK, S_TEXP, S_TLAST,
    S_OUT
  } state_t;

  state_t state;
  logic [DELTA_BITS-1:0] delta_ticks [TIMER_SLOTS];
  logic [SW-1:0] next_slot [TIMER_SLOTS];
  logic [SW-1:0] prev_slot [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] linked;
  logic [SW-1:0] head_slot, tail_slot;

  logic [SW-1:0] sid, cur;
  logic [DELTA_BITS-1:0] rem;
  logic [KW-1:0] cnt;
  logic [IW:0] guard;
  out_item_t res;
  logic out_more;

  // Shared arithmetic unit: subtract plus saturating add.
  logic [DELTA_BITS-1:0] op_a, op_b;
  logic [DELTA_BITS:0]   diff, sum;
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign sum  = {1'b0, op_a} + {1'b0, op_b};

  logic [IW-1:0] ci, si, hi, in_idx;
  assign ci = cur[IW-1:0];
  assign si = sid[IW-1:0];
  assign hi = head_slot[IW-1:0];
  assign in_idx = IW'(in.timer_id);

  logic id_ok, add_ok, del_ok, head_due;
  logic [DELTA_BITS-1:0] exp_m;
  assign id_ok = {{(32-4){1'b0}}, in.timer_id} < 32'(TIMER_SLOTS);
  assign exp_m = DELTA_BITS'(in.expires);
  assign add_ok = id_ok && exp_m != '0 && !linked[in_idx];
  assign del_ok = id_ok && linked[in_idx];
  // The head expires on this tick while the per-tick report limit is not reached.
  assign head_due = cnt != KW'(MAX_RESULTS) && head_slot != NIL && linked[hi]
                    && delta_ticks[hi] == '0;

  always_comb begin
    op_a = rem;
    op_b = delta_ticks[ci];
    if (state == S_DEL2) begin
      op_a = delta_ticks[ci];
      op_b = delta_ticks[si];
    end
  end

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.status = res.status;
  assign out.expired_valid = res.expired_valid;
  assign out.expired_id = res.expired_id;
  assign out.last = res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      linked <= '0;
      head_slot <= NIL;
      tail_slot <= NIL;
      res <= '0;
      out_more <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in.valid) begin
          sid <= SW'(in.timer_id);
          rem <= exp_m;
          cur <= head_slot;
          guard <= '0;
          cnt <= '0;
          out_more <= 1'b0;
          if (in.cmd == CMD_ADD && !add_ok) res <= '{ST_BAD_ADD, 1'b0, 4'd0, 1'b1};
          else if (in.cmd == CMD_DEL && !del_ok) res <= '{ST_NOTFOUND, 1'b0, 4'd0, 1'b1};
          else res <= '{ST_OK, 1'b0, 4'd0, 1'b1};
          if (in.cmd == CMD_ADD && add_ok) state <= S_WALK;
          else if (in.cmd == CMD_DEL && del_ok) state <= S_DEL;
          else if (in.cmd == CMD_TICK) state <= S_TICK;
          else state <= S_OUT;
        end
        S_WALK: begin
          if (cur == NIL || guard == (IW+1)'(TIMER_SLOTS)) begin
            cur <= NIL;
            state <= S_SPLICE;
          end else if (diff[DELTA_BITS]) begin
            // New timer fits before this entry.
            delta_ticks[ci] <= DELTA_BITS'(~diff + 1'b1);
            state <= S_SPLICE;
          end else begin
            rem <= diff[DELTA_BITS-1:0];
            cur <= next_slot[ci];
            guard <= guard + 1'b1;
          end
        end
        S_SPLICE: begin
          // cur is the successor; take predecessor from it or the tail.
          rem <= rem;
          prev_slot[si] <= (cur != NIL) ? prev_slot[ci] : tail_slot;
          next_slot[si] <= cur;
          delta_ticks[si] <= rem;
          linked[si] <= 1'b1;
          if (cur != NIL) prev_slot[ci] <= sid; else tail_slot <= sid;
          state <= S_SPLICE2;
        end
        S_SPLICE2: begin
          if (prev_slot[si] != NIL) next_slot[prev_slot[si][IW-1:0]] <= sid;
          else head_slot <= sid;
          state <= S_OUT;
        end
        S_DEL: begin
          cur <= next_slot[si];
          state <= S_DEL2;
        end
        S_DEL2: begin
          // The successor inherits the remaining delta, saturating on carry.
          if (delta_ticks[si] != '0 && cur != NIL)
            delta_ticks[ci] <= sum[DELTA_BITS] ? DMAX : sum[DELTA_BITS-1:0];
          if (prev_slot[si] != NIL) next_slot[prev_slot[si][IW-1:0]] <= cur;
          else head_slot <= cur;
          if (cur != NIL) prev_slot[ci] <= prev_slot[si];
          else tail_slot <= prev_slot[si];
          linked[si] <= 1'b0;
          next_slot[si] <= NIL;
          prev_slot[si] <= NIL;
          state <= S_OUT;
        end
        S_TICK: begin
          if (head_slot != NIL && delta_ticks[hi] != '0)
            delta_ticks[hi] <= delta_ticks[hi] - 1'b1;
          state <= S_TCHK;
        end
        S_TCHK: begin
          if (head_due) begin
            sid <= head_slot;
            state <= S_TEXP;
          end else begin
            res <= '{ST_OK, 1'b0, 4'd0, 1'b1};
            out_more <= 1'b0;
            state <= S_OUT;
          end
        end
        S_TEXP: begin
          cur <= next_slot[si];
          if (next_slot[si] != NIL) prev_slot[next_slot[si][IW-1:0]] <= prev_slot[si];
          else tail_slot <= prev_slot[si];
          head_slot <= next_slot[si];
          linked[si] <= 1'b0;
          next_slot[si] <= NIL;
          prev_slot[si] <= NIL;
          cnt <= cnt + 1'b1;
          res <= '{ST_OK, 1'b1, 4'(sid), 1'b0};
          state <= S_TLAST;
        end
        S_TLAST: begin
          // Look at the new head to tell whether this expiry is the last one.
          if (head_due) begin
            out_more <= 1'b1;
          end else begin
            res.last <= 1'b1;
            out_more <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: if (out.ready) begin
          if (out_more) begin
            state <= S_TCHK;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[sim/delta_list_timer_queue_core_tb.sv]
// Self-checking testbench for the delta-list timer queue core.
`timescale 1ns / 100ps

module delta_list_timer_queue_core_tb;
  import dltq_pkg::*;

  localparam int         SLOTS       = 16;
  localparam logic [4:0] NIL         = 5'd16;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         RAND_ITEMS  = 196;
  localparam int         CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  timer_id;
    logic [31:0] expires;
    bit          typed;
    logic [1:0]  status;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dltq_in_if  in_ch();
  dltq_out_if out_ch();

  delta_list_timer_queue_core dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the timer list.
  logic [31:0] slot_delta [SLOTS];
  logic [4:0]  slot_next  [SLOTS];
  logic [4:0]  slot_prev  [SLOTS];
  bit          slot_linked[SLOTS];
  logic [4:0]  list_head;
  logic [4:0]  list_tail;

  out_item_t pending_results[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        hold_request = 0;

  function automatic out_item_t mk_result(logic [1:0] st, logic ev, logic [3:0] id, logic lst);
    out_item_t r;
    r.status = st;
    r.expired_valid = ev;
    r.expired_id = id;
    r.last = lst;
    return r;
  endfunction

  task automatic unlink_timer(logic [4:0] s);
    logic [4:0] p;
    logic [4:0] n;
    p = slot_prev[s];
    n = slot_next[s];
    if (p != NIL) slot_next[p] = n; else list_head = n;
    if (n != NIL) slot_prev[n] = p; else list_tail = p;
    slot_linked[s] = 0;
    slot_next[s] = NIL;
    slot_prev[s] = NIL;
  endtask

  task automatic predict_timer_queue(in_item_t it);
    logic [31:0] rem;
    logic [32:0] sum;
    logic [4:0]  e;
    logic [4:0]  p;
    logic [4:0]  s;
    logic [4:0]  h;
    int          k;
    s = {1'b0, it.timer_id};
    case (it.cmd)
      CMD_ADD: begin
        rem = it.expires;
        if (rem == 0 || slot_linked[s]) begin
          pending_results.push_back(mk_result(ST_BAD_ADD, 1'b0, 4'd0, 1'b1));
        end else begin
          e = list_head;
          while (e != NIL) begin
            if (rem < slot_delta[e]) begin
              slot_delta[e] = slot_delta[e] - rem;
              break;
            end
            rem = rem - slot_delta[e];
            e = slot_next[e];
          end
          p = (e != NIL) ? slot_prev[e] : list_tail;
          slot_prev[s] = p;
          slot_next[s] = e;
          if (p != NIL) slot_next[p] = s; else list_head = s;
          if (e != NIL) slot_prev[e] = s; else list_tail = s;
          slot_delta[s] = rem;
          slot_linked[s] = 1;
          pending_results.push_back(mk_result(ST_OK, 1'b0, 4'd0, 1'b1));
        end
      end
      CMD_DEL: begin
        if (!slot_linked[s]) begin
          pending_results.push_back(mk_result(ST_NOTFOUND, 1'b0, 4'd0, 1'b1));
        end else begin
          e = slot_next[s];
          if (slot_delta[s] != 0 && e != NIL) begin
            sum = {1'b0, slot_delta[e]} + {1'b0, slot_delta[s]};
            slot_delta[e] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
          unlink_timer(s);
          pending_results.push_back(mk_result(ST_OK, 1'b0, 4'd0, 1'b1));
        end
      end
      CMD_TICK: begin
        k = 0;
        if (list_head != NIL && slot_delta[list_head] != 0)
          slot_delta[list_head] = slot_delta[list_head] - 1;
        while (k < MAX_RESULTS) begin
          h = list_head;
          if (h == NIL || !slot_linked[h] || slot_delta[h] != 0) break;
          unlink_timer(h);
          pending_results.push_back(mk_result(ST_OK, 1'b1, h[3:0], 1'b0));
          k++;
        end
        if (k == 0) pending_results.push_back(mk_result(ST_OK, 1'b0, 4'd0, 1'b1));
        else pending_results[$].last = 1'b1;
      end
      default: begin
        pending_results.push_back(mk_result(ST_OK, 1'b0, 4'd0, 1'b1));
      end
    endcase
  endtask

  // Offers one item and waits until the block takes it.
  task automatic send_item(in_item_t it, bit typed, logic [1:0] st);
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= it.cmd;
    in_ch.timer_id <= it.timer_id;
    in_ch.expires  <= it.expires;
    do @(posedge clk); while (!in_ch.ready);
    predict_timer_queue(it);
    if (typed) pending_results[$] = mk_result(st, 1'b0, 4'd0, 1'b1);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_gap(int g);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    int tries;
    r = $urandom_range(0, 99);
    it.timer_id = 4'($urandom_range(0, 15));
    it.expires = $urandom_range(1, 8);
    if (r < 40) begin
      it.cmd = CMD_ADD;
      for (tries = 0; tries < 8 && slot_linked[it.timer_id]; tries++)
        it.timer_id = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 19) == 0) it.expires = $urandom;
    end else if (r < 75) begin
      it.cmd = CMD_TICK;
    end else if (r < 90) begin
      it.cmd = CMD_DEL;
      for (tries = 0; tries < 8 && !slot_linked[it.timer_id]; tries++)
        it.timer_id = 4'($urandom_range(0, 15));
    end else begin
      it.cmd = 2'($urandom_range(0, 3));
      it.expires = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    end
    return it;
  endfunction

  dir_row_t directed[] = '{
    '{CMD_TICK,   4'd0,  32'd0,          1, ST_OK},
    '{CMD_ADD,    4'd0,  32'd0,          1, ST_BAD_ADD},
    '{CMD_DEL,    4'd5,  32'd0,          1, ST_NOTFOUND},
    '{CMD_UNUSED, 4'd15, 32'hFFFF_FFFF,  1, ST_OK},
    '{CMD_ADD,    4'd15, 32'hFFFF_FFFF,  0, ST_OK},
    '{CMD_ADD,    4'd15, 32'd7,          1, ST_BAD_ADD},
    '{CMD_ADD,    4'd1,  32'd1,          0, ST_OK},
    '{CMD_ADD,    4'd2,  32'd3,          0, ST_OK},
    '{CMD_ADD,    4'd3,  32'd3,          0, ST_OK},
    '{CMD_ADD,    4'd4,  32'd3,          0, ST_OK},
    '{CMD_ADD,    4'd5,  32'd2,          0, ST_OK},
    '{CMD_ADD,    4'd6,  32'h8000_0000,  0, ST_OK},
    '{CMD_TICK,   4'd0,  32'd0,          0, ST_OK},
    '{CMD_DEL,    4'd6,  32'd0,          0, ST_OK},
    '{CMD_DEL,    4'd6,  32'd0,          1, ST_NOTFOUND},
    '{CMD_TICK,   4'd0,  32'd0,          0, ST_OK},
    '{CMD_DEL,    4'd3,  32'd0,          0, ST_OK},
    '{CMD_TICK,   4'd0,  32'd0,          0, ST_OK},
    '{CMD_ADD,    4'd7,  32'd1,          0, ST_OK},
    '{CMD_ADD,    4'd8,  32'd1,          0, ST_OK},
    '{CMD_ADD,    4'd9,  32'd1,          0, ST_OK},
    '{CMD_TICK,   4'd0,  32'd0,          0, ST_OK},
    '{CMD_DEL,    4'd15, 32'd0,          0, ST_OK},
    '{CMD_TICK,   4'd0,  32'd0,          0, ST_OK}
  };

  // Result side: random ready, with one long hold-off on request.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request && hold == 0) begin
        hold = 400;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < 70) ||
                        ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b0);
        if ($urandom_range(0, 49) == 0) hold = $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = mk_result(out_ch.status, out_ch.expired_valid, out_ch.expired_id, out_ch.last);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int i;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.timer_id = '0;
    in_ch.expires = '0;
    for (i = 0; i < SLOTS; i++) begin
      slot_linked[i] = 0;
      slot_next[i] = NIL;
      slot_prev[i] = NIL;
      slot_delta[i] = '0;
    end
    list_head = NIL;
    list_tail = NIL;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[j]) begin
      it.cmd = directed[j].cmd;
      it.timer_id = directed[j].timer_id;
      it.expires = directed[j].expires;
      send_item(it, directed[j].typed, directed[j].status);
      idle_gap(pick_gap());
    end

    for (i = 0; i < RAND_ITEMS; i++) begin
      // The results back up while the sender keeps offering items.
      if (i == 60) hold_request = 1;
      if (i == 140) begin
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      send_item(random_item(), 0, ST_OK);
      if (i >= 100 && i < 120) idle_gap(0);
      else idle_gap(pick_gap());
    end
    in_ch.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[delta_list_timer_queue_core.f]
rtl/dltq_pkg.sv
rtl/dltq_in_if.sv
rtl/delta_list_timer_queue_core.sv
sim/delta_list_timer_queue_core_tb.sv
